### design/lpe_pkg.sv
// Shared types, codes and constants of the line position estimator.
`default_nettype none

package lpe_pkg;

    // Build-time defaults
    localparam int DEFAULT_MAX_SENSORS = 15;
    localparam int DEFAULT_RAW_BITS    = 12;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int SIDX_W  = 4;
    localparam int CVAL_W  = 10;
    localparam int POS_W   = 14;
    localparam int THR_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int WSUM_W  = 16;
    localparam int WTOT_W  = 32;
    localparam int PROD_W  = 24;

    // Shared divider geometry
    localparam int DIV_DVD_W = 32;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = 6;

    // Arithmetic constants
    localparam int SCALE   = 1000;
    localparam int POS_SAT = 16383;

    // Commands
    localparam logic [CMD_W-1:0] CMD_POSITION  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CALIBRATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAW         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THRESHOLD = 3'd4;

    // Register reset values
    localparam logic [3:0]       RST_SENSOR_COUNT    = 4'd15;
    localparam logic [11:0]      RST_MAX_RAW         = 12'd1023;
    localparam logic             RST_CALIBRATE_EN    = 1'b1;
    localparam logic [THR_W-1:0] RST_LINE_THRESHOLD  = 10'd350;
    localparam logic [THR_W-1:0] RST_NOISE_THRESHOLD = 10'd60;

    // Divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

    // Limit store control
    typedef struct packed {
        logic fill;
        logic update;
        logic burst_first;
        logic burst_last;
    } store_ctl_t;

endpackage

`default_nettype wire

### design/lpe_div.sv
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none

module lpe_div import lpe_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DVD_W-1:0] dvd_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DVD_W-1:0] quo_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (req.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= req.iters;
                dvd_reg  <= req.dividend;
                den_reg  <= req.divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                // shift in the next dividend bit and subtract where it fits
                dvd_reg  <= {dvd_reg[DIV_DVD_W-2:0], 1'b0};
                quo_reg  <= {quo_reg[DIV_DVD_W-2:0], fits};
                rem_reg  <= fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == DIV_CNT_W'(1));
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### design/lpe_cal_store.sv
// Per-sensor calibration limits and burst run extremes.
`default_nettype none

module lpe_cal_store import lpe_pkg::*; #(
    parameter int MAX_SENSORS = DEFAULT_MAX_SENSORS,
    parameter int RAW_BITS    = DEFAULT_RAW_BITS,
    localparam int IDX_W      = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1
) (
    input  wire logic                aclk,
    input  wire store_ctl_t          ctl,
    input  wire logic [IDX_W-1:0]    idx,
    input  wire logic [RAW_BITS-1:0] raw,
    input  wire logic [RAW_BITS-1:0] fill_low,
    output logic      [RAW_BITS-1:0] rd_high,
    output logic      [RAW_BITS-1:0] rd_low
);

    logic [RAW_BITS-1:0] cal_high_mem   [MAX_SENSORS];
    logic [RAW_BITS-1:0] cal_low_mem    [MAX_SENSORS];
    logic [RAW_BITS-1:0] burst_high_mem [MAX_SENSORS];
    logic [RAW_BITS-1:0] burst_low_mem  [MAX_SENSORS];

    logic [RAW_BITS-1:0] nb_high;
    logic [RAW_BITS-1:0] nb_low;

    always_comb begin
        if (ctl.burst_first) begin
            nb_high = raw;
            nb_low  = raw;
        end else begin
            nb_high = (raw > burst_high_mem[idx]) ? raw : burst_high_mem[idx];
            nb_low  = (raw < burst_low_mem[idx])  ? raw : burst_low_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fill) begin
            cal_high_mem[idx] <= '0;
            cal_low_mem[idx]  <= fill_low;
        end else if (ctl.update) begin
            burst_high_mem[idx] <= nb_high;
            burst_low_mem[idx]  <= nb_low;
            // widen limits only when the whole burst lies beyond them
            if (ctl.burst_last) begin
                if (nb_low > cal_high_mem[idx]) begin
                    cal_high_mem[idx] <= nb_low;
                end
                if (nb_high < cal_low_mem[idx]) begin
                    cal_low_mem[idx] <= nb_high;
                end
            end
        end
    end

    assign rd_high = cal_high_mem[idx];
    assign rd_low  = cal_low_mem[idx];

endmodule

`default_nettype wire

### design/line_position_estimator.sv
// Line position estimator: sequencer, accumulators and configuration registers.
// One item at a time; s_ready is high only while idle. A first calibration fills the
// limits of all MAX_SENSORS entries before it calibrates, and clear fills them alone.
// An in-range position reading with a usable span is normalised by RAW_BITS+10 steps
// of the shared divider; a last sensor may add the 32-step centroid division.
// A stalled result register holds the sequencer. Synchronous active-low reset.
`default_nettype none

module line_position_estimator import lpe_pkg::*; #(
    parameter int MAX_SENSORS = DEFAULT_MAX_SENSORS,
    parameter int RAW_BITS    = DEFAULT_RAW_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CMD_W-1:0]      s_command,
    input  wire logic [SIDX_W-1:0]     s_sensor_index,
    input  wire logic [RAW_BITS-1:0]   s_raw_value,
    input  wire logic                  s_last_sensor,
    input  wire logic                  s_burst_first,
    input  wire logic                  s_burst_last,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CVAL_W-1:0]          m_calibrated_value,
    output logic                       m_position_valid,
    output logic [POS_W-1:0]           m_position,
    output logic                       m_line_seen,
    output logic                       m_not_calibrated
);

    localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int NUM_W = RAW_BITS + 10;
    localparam logic [SIDX_W-1:0] MAX_N = SIDX_W'(MAX_SENSORS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FILL, ST_CAL, ST_NORM, ST_NDIV, ST_ACC, ST_SCAN, ST_CDIV, ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [SIDX_W-1:0] sensor_count_reg;
    logic [11:0]       max_raw_reg;
    logic              cal_en_reg;
    logic [THR_W-1:0]  line_th_reg;
    logic [THR_W-1:0]  noise_th_reg;

    // item being worked on
    logic [SIDX_W-1:0]   idx_reg;
    logic [RAW_BITS-1:0] raw_reg;
    logic                last_reg;
    logic                bfirst_reg;
    logic                blast_reg;
    logic                fill_then_cal_reg;
    logic [IDX_W-1:0]    fill_cnt_reg;
    logic                neg_reg;
    logic [POS_W-1:0]    w_reg;
    logic [CVAL_W-1:0]   cval_reg;

    // scan state
    logic              is_cal_reg;
    logic [WTOT_W-1:0] wtot_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic              seen_reg;
    logic [POS_W-1:0]  last_pos_reg;

    // pending result
    logic              res_pvalid_reg;
    logic [POS_W-1:0]  res_pos_reg;
    logic              res_seen_reg;
    logic              res_notcal_reg;

    // result register
    logic              m_valid_reg;
    logic [CVAL_W-1:0] m_cval_reg;
    logic              m_pvalid_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic              m_seen_reg;
    logic              m_notcal_reg;

    // shared units
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    store_ctl_t          st_ctl;
    logic [IDX_W-1:0]    st_idx;
    logic [RAW_BITS-1:0] st_fill_low;
    logic [RAW_BITS-1:0] rd_high;
    logic [RAW_BITS-1:0] rd_low;

    // datapath
    logic [SIDX_W-1:0]    eff_n;
    logic                 inrange;
    logic [POS_W-1:0]     span;
    logic [DIV_DEN_W-1:0] den;
    logic signed [RAW_BITS:0] diff;
    logic [RAW_BITS-1:0]  mag;
    logic [NUM_W-1:0]     num_mag;
    logic                 norm_go;
    logic [15:0]          q16;
    logic [CVAL_W-1:0]    cval_q;
    logic [PROD_W-1:0]    prod;
    logic [POS_W-1:0]     cent_pos;
    logic [POS_W-1:0]     lost_pos;

    always_comb begin
        if (sensor_count_reg == '0) begin
            eff_n = SIDX_W'(1);
        end else if (sensor_count_reg > MAX_N) begin
            eff_n = MAX_N;
        end else begin
            eff_n = sensor_count_reg;
        end
    end

    assign inrange  = idx_reg < eff_n;
    assign span     = POS_W'(eff_n - SIDX_W'(1)) * POS_W'(SCALE);
    assign lost_pos = (last_pos_reg < (span >> 1)) ? '0 : span;

    // normalisation operands
    assign den     = DIV_DEN_W'(rd_high) - DIV_DEN_W'(rd_low);
    assign diff    = $signed({1'b0, raw_reg}) - $signed({1'b0, rd_low});
    assign mag     = diff[RAW_BITS] ? RAW_BITS'(-diff) : diff[RAW_BITS-1:0];
    assign num_mag = NUM_W'(mag) * NUM_W'(SCALE);
    assign norm_go = is_cal_reg && inrange && (den != '0);

    // restore the sign and keep 16 bits, then clamp to 0..1000
    assign q16 = neg_reg ? (16'd0 - div_rsp.quotient[15:0]) : div_rsp.quotient[15:0];
    always_comb begin
        if (q16[15]) begin
            cval_q = '0;
        end else if (q16 > 16'(SCALE)) begin
            cval_q = CVAL_W'(SCALE);
        end else begin
            cval_q = q16[CVAL_W-1:0];
        end
    end

    assign prod     = PROD_W'(cval_reg) * PROD_W'(w_reg);
    assign cent_pos = (div_rsp.quotient > DIV_DVD_W'(POS_SAT)) ? POS_W'(POS_SAT)
                                                                : div_rsp.quotient[POS_W-1:0];

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {num_mag, {(DIV_DVD_W-NUM_W){1'b0}}};
        div_req.divisor  = den;
        div_req.iters    = DIV_CNT_W'(NUM_W);
        if (state_reg == ST_NORM) begin
            div_req.start = norm_go;
        end else if (state_reg == ST_SCAN) begin
            div_req.start    = seen_reg && (wsum_reg != '0);
            div_req.dividend = wtot_reg;
            div_req.divisor  = wsum_reg;
            div_req.iters    = DIV_CNT_W'(DIV_DVD_W);
        end
    end

    assign st_ctl.fill        = state_reg == ST_FILL;
    assign st_ctl.update      = (state_reg == ST_CAL) && inrange;
    assign st_ctl.burst_first = bfirst_reg;
    assign st_ctl.burst_last  = blast_reg;
    assign st_idx      = (state_reg == ST_FILL) ? fill_cnt_reg : idx_reg[IDX_W-1:0];
    assign st_fill_low = RAW_BITS'(16'(max_raw_reg));

    lpe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    lpe_cal_store #(
        .MAX_SENSORS (MAX_SENSORS),
        .RAW_BITS    (RAW_BITS)
    ) u_store (
        .aclk     (aclk),
        .ctl      (st_ctl),
        .idx      (st_idx),
        .raw      (raw_reg),
        .fill_low (st_fill_low),
        .rd_high  (rd_high),
        .rd_low   (rd_low)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            sensor_count_reg <= RST_SENSOR_COUNT;
            max_raw_reg      <= RST_MAX_RAW;
            cal_en_reg       <= RST_CALIBRATE_EN;
            line_th_reg      <= RST_LINE_THRESHOLD;
            noise_th_reg     <= RST_NOISE_THRESHOLD;
            is_cal_reg       <= 1'b0;
            wtot_reg         <= '0;
            wsum_reg         <= '0;
            seen_reg         <= 1'b0;
            last_pos_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SENSOR_COUNT:    sensor_count_reg <= cfg_data[SIDX_W-1:0];
                    CFG_MAX_RAW:         max_raw_reg      <= cfg_data;
                    CFG_CALIBRATE_EN:    cal_en_reg       <= cfg_data[0];
                    CFG_LINE_THRESHOLD:  line_th_reg      <= cfg_data[THR_W-1:0];
                    CFG_NOISE_THRESHOLD: noise_th_reg     <= cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            // drop the result once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        idx_reg        <= s_sensor_index;
                        raw_reg        <= s_raw_value;
                        last_reg       <= s_last_sensor;
                        bfirst_reg     <= s_burst_first;
                        blast_reg      <= s_burst_last;
                        cval_reg       <= '0;
                        res_pvalid_reg <= 1'b0;
                        res_pos_reg    <= '0;
                        res_seen_reg   <= 1'b0;
                        res_notcal_reg <= (s_command == CMD_POSITION) && !is_cal_reg;
                        fill_cnt_reg   <= '0;
                        case (s_command)
                            CMD_POSITION: begin
                                state_reg <= ST_NORM;
                            end
                            CMD_CALIBRATE: begin
                                if (!cal_en_reg) begin
                                    state_reg <= ST_EMIT;
                                end else if (!is_cal_reg) begin
                                    // first calibration fills the limits first
                                    is_cal_reg        <= 1'b1;
                                    fill_then_cal_reg <= 1'b1;
                                    state_reg         <= ST_FILL;
                                end else begin
                                    state_reg <= ST_CAL;
                                end
                            end
                            CMD_CLEAR: begin
                                fill_then_cal_reg <= 1'b0;
                                state_reg         <= ST_FILL;
                            end
                            default: begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                    if (fill_cnt_reg == IDX_W'(MAX_SENSORS - 1)) begin
                        state_reg <= fill_then_cal_reg ? ST_CAL : ST_EMIT;
                    end
                end
                ST_CAL: begin
                    state_reg <= ST_EMIT;
                end
                ST_NORM: begin
                    neg_reg   <= diff[RAW_BITS];
                    w_reg     <= POS_W'(idx_reg) * POS_W'(SCALE);
                    state_reg <= norm_go ? ST_NDIV : ST_ACC;
                end
                ST_NDIV: begin
                    if (div_rsp.done) begin
                        cval_reg  <= cval_q;
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    // a zero reading never passes either threshold
                    if (cval_reg > line_th_reg) begin
                        seen_reg <= 1'b1;
                    end
                    if (cval_reg > noise_th_reg) begin
                        wtot_reg <= wtot_reg + WTOT_W'(prod);
                        wsum_reg <= wsum_reg + WSUM_W'(cval_reg);
                    end
                    state_reg <= last_reg ? ST_SCAN : ST_EMIT;
                end
                ST_SCAN: begin
                    res_pvalid_reg <= 1'b1;
                    res_seen_reg   <= seen_reg;
                    wtot_reg       <= '0;
                    wsum_reg       <= '0;
                    seen_reg       <= 1'b0;
                    if (!seen_reg) begin
                        res_pos_reg <= lost_pos;
                        state_reg   <= ST_EMIT;
                    end else if (wsum_reg != '0) begin
                        state_reg <= ST_CDIV;
                    end else begin
                        res_pos_reg <= last_pos_reg;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_CDIV: begin
                    if (div_rsp.done) begin
                        last_pos_reg <= cent_pos;
                        res_pos_reg  <= cent_pos;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold until the result register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_cval_reg   <= cval_reg;
                        m_pvalid_reg <= res_pvalid_reg;
                        m_pos_reg    <= res_pos_reg;
                        m_seen_reg   <= res_seen_reg;
                        m_notcal_reg <= res_notcal_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready            = state_reg == ST_IDLE;
    assign m_valid            = m_valid_reg;
    assign m_calibrated_value = m_cval_reg;
    assign m_position_valid   = m_pvalid_reg;
    assign m_position         = m_pos_reg;
    assign m_line_seen        = m_seen_reg;
    assign m_not_calibrated   = m_notcal_reg;

endmodule

`default_nettype wire

### dv/line_position_estimator_tb.sv
// Self-checking testbench for the line position estimator.
`default_nettype none

module line_position_estimator_tb;
    import lpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SENSORS = DEFAULT_MAX_SENSORS;
    localparam int RAW_BITS    = DEFAULT_RAW_BITS;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 22;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [CVAL_W-1:0] cval;
        logic              pvalid;
        logic [POS_W-1:0]  pos;
        logic              seen;
        logic              notcal;
    } lpe_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command      = CMD_POSITION;
    logic [SIDX_W-1:0]   s_sensor_index = '0;
    logic [RAW_BITS-1:0] s_raw_value    = '0;
    logic                s_last_sensor  = 1'b0;
    logic                s_burst_first  = 1'b0;
    logic                s_burst_last   = 1'b0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CVAL_W-1:0]   m_calibrated_value;
    logic                m_position_valid;
    logic [POS_W-1:0]    m_position;
    logic                m_line_seen;
    logic                m_not_calibrated;

    line_position_estimator #(
        .MAX_SENSORS (MAX_SENSORS),
        .RAW_BITS    (RAW_BITS)
    ) uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_sensor_index     (s_sensor_index),
        .s_raw_value        (s_raw_value),
        .s_last_sensor      (s_last_sensor),
        .s_burst_first      (s_burst_first),
        .s_burst_last       (s_burst_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_calibrated_value (m_calibrated_value),
        .m_position_valid   (m_position_valid),
        .m_position         (m_position),
        .m_line_seen        (m_line_seen),
        .m_not_calibrated   (m_not_calibrated)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Register copies
    logic [3:0]          cur_count    = RST_SENSOR_COUNT;
    logic [11:0]         cur_max_raw  = RST_MAX_RAW;
    logic                cur_cal_en   = RST_CALIBRATE_EN;
    logic [THR_W-1:0]    cur_line_thr = RST_LINE_THRESHOLD;
    logic [THR_W-1:0]    cur_noise_thr = RST_NOISE_THRESHOLD;

    // Estimator state
    logic [RAW_BITS-1:0] lim_high [MAX_SENSORS];
    logic [RAW_BITS-1:0] lim_low  [MAX_SENSORS];
    logic [RAW_BITS-1:0] run_high [MAX_SENSORS];
    logic [RAW_BITS-1:0] run_low  [MAX_SENSORS];
    bit                  run_opened [MAX_SENSORS];
    bit                  calibrated     = 1'b0;
    logic [WTOT_W-1:0]   centroid_num   = '0;
    logic [WSUM_W-1:0]   centroid_den   = '0;
    bit                  line_hit       = 1'b0;
    logic [POS_W-1:0]    remembered_pos = '0;

    lpe_result_t expected_results [$];

    bit steady = 1'b0;
    int mismatch_count = 0;
    int useful_items = 0;
    int n_position = 0, n_calibrate = 0, n_clear = 0, n_other = 0;
    int results_seen = 0, scans_done = 0, lines_seen = 0, settings_applied = 0;

    function automatic int eff_count();
        return (cur_count == 4'd0) ? 1 : int'(cur_count);
    endfunction

    function automatic void reset_limits();
        for (int k = 0; k < MAX_SENSORS; k++) begin
            lim_high[k] = '0;
            lim_low[k]  = cur_max_raw[RAW_BITS-1:0];
        end
    endfunction

    // Normalise to 0..1000 with a wrapped 16-bit span and a 16-bit signed quotient
    function automatic logic [CVAL_W-1:0] scale_reading(input logic [RAW_BITS-1:0] raw,
                                                        input logic [RAW_BITS-1:0] hi,
                                                        input logic [RAW_BITS-1:0] lo);
        logic [15:0] span16;
        logic [15:0] q16;
        int den, r, l, q;
        span16 = 16'(hi) - 16'(lo);
        if (span16 == 16'd0)
            return '0;
        den = {16'd0, span16};
        r = {20'd0, raw};
        l = {20'd0, lo};
        q = ((r - l) * SCALE) / den;
        q16 = q[15:0];
        if (q16[15])
            return '0;
        if (q16 > 16'd1000)
            return 10'd1000;
        return q16[CVAL_W-1:0];
    endfunction

    task automatic predict_reading(input logic [CMD_W-1:0] cmd, input logic [SIDX_W-1:0] idx,
                                   input logic [RAW_BITS-1:0] raw, input logic last,
                                   input logic bf, input logic bl, output lpe_result_t r);
        int n, span;
        bit inr;
        logic [CVAL_W-1:0] cv;
        logic [31:0] q;
        n = eff_count();
        inr = int'(idx) < n;
        r = '0;
        case (cmd)
            CMD_CALIBRATE: begin
                if (cur_cal_en) begin
                    if (!calibrated) begin
                        reset_limits();
                        calibrated = 1'b1;
                    end
                    if (inr) begin
                        if (bf) begin
                            run_high[idx] = raw;
                            run_low[idx]  = raw;
                            run_opened[idx] = 1'b1;
                        end else begin
                            if (raw > run_high[idx]) run_high[idx] = raw;
                            if (raw < run_low[idx])  run_low[idx]  = raw;
                        end
                        // commit only limits that the whole burst lies beyond
                        if (bl) begin
                            if (run_low[idx] > lim_high[idx]) lim_high[idx] = run_low[idx];
                            if (run_high[idx] < lim_low[idx]) lim_low[idx]  = run_high[idx];
                        end
                    end
                end
            end
            CMD_CLEAR: reset_limits();
            CMD_POSITION: begin
                if (!calibrated) begin
                    r.notcal = 1'b1;
                end else if (inr) begin
                    cv = scale_reading(raw, lim_high[idx], lim_low[idx]);
                    r.cval = cv;
                    if (cv > cur_line_thr) line_hit = 1'b1;
                    if (cv > cur_noise_thr) begin
                        centroid_num = centroid_num + 32'(cv) * (32'(idx) * 32'd1000);
                        centroid_den = centroid_den + 16'(cv);
                    end
                end
                if (last) begin
                    r.pvalid = 1'b1;
                    span = (n - 1) * SCALE;
                    if (!line_hit) begin
                        r.pos = (int'(remembered_pos) < span / 2) ? '0 : POS_W'(span);
                    end else begin
                        r.seen = 1'b1;
                        if (centroid_den != '0) begin
                            q = centroid_num / {16'd0, centroid_den};
                            remembered_pos = (q > POS_SAT) ? POS_W'(POS_SAT) : q[POS_W-1:0];
                        end
                        r.pos = remembered_pos;
                    end
                    centroid_num = '0;
                    centroid_den = '0;
                    line_hit = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Send one item; s_valid stays high after acceptance until the next gap
    task automatic send_reading(input logic [CMD_W-1:0] cmd, input logic [SIDX_W-1:0] idx,
                                input logic [RAW_BITS-1:0] raw, input logic last,
                                input logic bf, input logic bl);
        lpe_result_t want;
        // never let a burst extend from an entry that has not been opened
        if (cmd == CMD_CALIBRATE && cur_cal_en && int'(idx) < eff_count() && !run_opened[idx])
            bf = 1'b1;
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_sensor_index <= idx;
        s_raw_value    <= raw;
        s_last_sensor  <= last;
        s_burst_first  <= bf;
        s_burst_last   <= bl;
        do @(posedge aclk); while (!s_ready);
        predict_reading(cmd, idx, raw, last, bf, bl, want);
        expected_results.push_back(want);
        case (cmd)
            CMD_POSITION:  n_position++;
            CMD_CALIBRATE: n_calibrate++;
            CMD_CLEAR:     n_clear++;
            default:       n_other++;
        endcase
        if (!(cmd == CMD_UNUSED || (cmd == CMD_CALIBRATE && !cur_cal_en)))
            useful_items++;
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        case (index)
            CFG_SENSOR_COUNT:    cur_count     = value[3:0];
            CFG_MAX_RAW:         cur_max_raw   = value[11:0];
            CFG_CALIBRATE_EN:    cur_cal_en    = value[0];
            CFG_LINE_THRESHOLD:  cur_line_thr  = value[THR_W-1:0];
            CFG_NOISE_THRESHOLD: cur_noise_thr = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input int count, input int maxr, input int cen,
                                input int lthr, input int nthr);
        wait_results();
        // let the sequencer settle back to idle
        repeat (8) @(posedge aclk);
        write_reg(CFG_SENSOR_COUNT,    CFG_DATA_W'(count));
        write_reg(CFG_MAX_RAW,         CFG_DATA_W'(maxr));
        write_reg(CFG_CALIBRATE_EN,    CFG_DATA_W'(cen));
        write_reg(CFG_LINE_THRESHOLD,  CFG_DATA_W'(lthr));
        write_reg(CFG_NOISE_THRESHOLD, CFG_DATA_W'(nthr));
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // Dark burst then bright burst: gives each sensor a usable span
    task automatic calibrate_array();
        int n;
        n = eff_count();
        for (int s = 0; s < 4; s++)
            for (int i = 0; i < n; i++)
                send_reading(CMD_CALIBRATE, SIDX_W'(i),
                             (s < 2) ? RAW_BITS'($urandom_range(400)) :
                                       RAW_BITS'($urandom_range(4095, 600)),
                             i == n - 1, s == 0 || s == 2, s == 1 || s == 3);
    endtask

    task automatic run_traffic(input int quota);
        int goal, kind, n, c, k, len;
        bit dark, commit, scramble;
        logic [RAW_BITS-1:0] raw;
        goal = useful_items + quota;
        calibrate_array();
        while (useful_items < goal) begin
            n = eff_count();
            kind = $urandom_range(99);
            if (kind < 15) begin
                k = $urandom_range(3, 1);
                dark = 1'($urandom_range(1));
                commit = $urandom_range(9) != 0;
                for (int s = 0; s < k; s++)
                    for (int i = 0; i < n; i++) begin
                        raw = dark ? RAW_BITS'($urandom_range(400)) :
                                     RAW_BITS'($urandom_range(4095, 600));
                        send_reading(CMD_CALIBRATE, SIDX_W'(i), raw, i == n - 1,
                                     s == 0, commit && s == k - 1);
                    end
            end else if (kind < 80) begin
                c = $urandom_range(n);
                scramble = $urandom_range(4) == 0;
                len = ($urandom_range(9) == 0) ? $urandom_range(n, 1) : n;
                for (int i = 0; i < len; i++) begin
                    if (scramble)
                        raw = RAW_BITS'($urandom_range(4095));
                    else if (c < n && (i == c || i == c + 1 || i + 1 == c))
                        raw = RAW_BITS'($urandom_range(4095, 500));
                    else
                        raw = RAW_BITS'($urandom_range(500));
                    send_reading(CMD_POSITION, SIDX_W'(i), raw, i == n - 1,
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end else if (kind < 83) begin
                send_reading(CMD_CLEAR, SIDX_W'($urandom_range(15)),
                             RAW_BITS'($urandom_range(4095)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (kind < 85) begin
                wait_results();
            end else begin
                send_reading(CMD_W'($urandom_range(3)), SIDX_W'($urandom_range(15)),
                             RAW_BITS'($urandom_range(4095)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_uncalibrated();
        send_reading(CMD_POSITION, 4'd0, 12'd0, 1'b0, 1'b0, 1'b0);
        send_reading(CMD_POSITION, 4'd14, 12'd4095, 1'b1, 1'b1, 1'b1);
        send_reading(CMD_UNUSED, 4'd15, 12'd4095, 1'b1, 1'b1, 1'b1);
        send_reading(CMD_CLEAR, 4'd15, 12'd4095, 1'b1, 1'b1, 1'b1);
        send_reading(CMD_POSITION, 4'd3, 12'd100, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_first_calibration();
        send_reading(CMD_CALIBRATE, 4'd0, 12'd100, 1'b0, 1'b1, 1'b0);
        send_reading(CMD_CALIBRATE, 4'd0, 12'd900, 1'b0, 1'b0, 1'b1);
        send_reading(CMD_CALIBRATE, 4'd1, 12'd1000, 1'b0, 1'b1, 1'b1);
        send_reading(CMD_CALIBRATE, 4'd1, 12'd50, 1'b0, 1'b1, 1'b1);
        send_reading(CMD_CALIBRATE, 4'd2, 12'd4095, 1'b0, 1'b1, 1'b1);
        send_reading(CMD_CALIBRATE, 4'd2, 12'd0, 1'b0, 1'b1, 1'b1);
        send_reading(CMD_CALIBRATE, 4'd15, 12'd77, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_position_scans();
        send_reading(CMD_POSITION, 4'd1, 12'd1000, 1'b0, 1'b0, 1'b0);
        send_reading(CMD_POSITION, 4'd2, 12'd0, 1'b0, 1'b0, 1'b0);
        send_reading(CMD_POSITION, 4'd15, 12'd7, 1'b0, 1'b0, 1'b0);
        send_reading(CMD_POSITION, 4'd0, 12'd500, 1'b1, 1'b0, 1'b0);
        // hold off until the pipeline has emptied
        wait_results();
        send_reading(CMD_POSITION, 4'd1, 12'd50, 1'b1, 1'b0, 1'b0);
        send_reading(CMD_POSITION, 4'd2, 12'd4095, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_config_extremes();
        // line below noise: seen but no weight, so the position is held
        apply_config(1, 4095, 1, 0, 1000);
        send_reading(CMD_CALIBRATE, 4'd0, 12'd4095, 1'b0, 1'b1, 1'b1);
        send_reading(CMD_POSITION, 4'd0, 12'd3000, 1'b1, 1'b0, 1'b0);
        send_reading(CMD_POSITION, 4'd1, 12'd4095, 1'b1, 1'b0, 1'b0);
        apply_config(0, 0, 0, 1000, 0);
        send_reading(CMD_CALIBRATE, 4'd0, 12'd0, 1'b0, 1'b1, 1'b1);
        send_reading(CMD_CLEAR, 4'd0, 12'd0, 1'b0, 1'b0, 1'b0);
        send_reading(CMD_POSITION, 4'd0, 12'd1234, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        apply_config(15, 1023, 1, 350, 60);
        run_traffic(140);
        apply_config(5, 4095, 1, 0, 0);
        run_traffic(120);
        apply_config(1, 0, 1, 1000, 1000);
        run_traffic(60);
        apply_config(0, 2047, 1, 500, 100);
        run_traffic(50);
        apply_config(8, 1023, 0, 200, 30);
        run_traffic(80);
        steady = 1'b1;
        apply_config(15, $urandom_range(4095), 1, $urandom_range(1000), $urandom_range(1000));
        run_traffic(130);
        steady = 1'b0;
        apply_config($urandom_range(15, 1), $urandom_range(4095), 1,
                     $urandom_range(1000), $urandom_range(1000));
        run_traffic(130);
    endtask

    // Result side: random back-pressure except in steady stretches
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        lpe_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (m_calibrated_value !== want.cval)
                    report_mismatch($sformatf("calibrated_value got %0d want %0d",
                                              m_calibrated_value, want.cval));
                if (m_position_valid !== want.pvalid)
                    report_mismatch($sformatf("position_valid got %0b want %0b",
                                              m_position_valid, want.pvalid));
                if (m_position !== want.pos)
                    report_mismatch($sformatf("position got %0d want %0d",
                                              m_position, want.pos));
                if (m_line_seen !== want.seen)
                    report_mismatch($sformatf("line_seen got %0b want %0b",
                                              m_line_seen, want.seen));
                if (m_not_calibrated !== want.notcal)
                    report_mismatch($sformatf("not_calibrated got %0b want %0b",
                                              m_not_calibrated, want.notcal));
                if (want.pvalid) scans_done++;
                if (want.seen) lines_seen++;
            end
        end
    end

    initial begin
        #20ms;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int waited;
        for (int k = 0; k < MAX_SENSORS; k++)
            run_opened[k] = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_uncalibrated();
        test_first_calibration();
        test_position_scans();
        test_config_extremes();
        test_random_traffic();
        s_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        // watch for stray results after the last expected one
        repeat (100) @(posedge aclk);
        $display("Sent %0d items: %0d position, %0d calibration, %0d clear, %0d unused;",
                 n_position + n_calibrate + n_clear + n_other,
                 n_position, n_calibrate, n_clear, n_other);
        $display("checked %0d results, %0d scans (%0d with line) over %0d register settings",
                 results_seen, scans_done, lines_seen, settings_applied);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
design/lpe_pkg.sv
design/lpe_div.sv
design/lpe_cal_store.sv
design/line_position_estimator.sv
dv/line_position_estimator_tb.sv
